FILE: hw/rtl/ssg_pkg.sv
package ssg_pkg;

	localparam int unsigned PEAK = 32767;
	localparam logic [63:0] Q30_ONE = 64'd1073741824;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	// register map, word index into the apb space
	localparam logic [1:0] REG_PHASE_INC = 2'd0;
	localparam logic [1:0] REG_AMPLITUDE = 2'd1;
	localparam logic [1:0] REG_SAMPLE_COUNT = 2'd2;

	typedef logic [14:0] mag_t;
	typedef logic [63:0] wide_t;

endpackage

FILE: hw/rtl/sine_sample_generator.sv
// channel  | direction | handshake            | payload
// in       | input     | in_valid / in_stall   | restart
// out      | output    | out_valid / out_stall | sample, last
// cfg      | input     | apb psel/penable      | phase_increment, amplitude, sample_count
//
// one sample per clock sustained while out_stall is low; an input beat reaches its output beat through
// the registered stages (quarter-wave rom read, 15x15 multiply, divide by 32767 with one correction step)
// the phase accumulator and sample index advance at the input beat, so beats may follow
// every cycle; out_stall with a beat waiting at the output freezes the whole three-stage
// pipe and raises in_stall
// arst_n clears the pipe valids, the phase, the index and the registers (sample_count to 1)
module sine_sample_generator #(
	parameter int PHASE_BITS = 32,
	parameter int QUARTER_TABLE_DEPTH = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        restart,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] sample,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int ADDR_BITS = $clog2(QUARTER_TABLE_DEPTH + 1) - 1;
	localparam int TAB_SIZE = 1 << ADDR_BITS;

	// configuration registers
	logic [31:0] phase_inc_q;
	logic [15:0] amplitude_q;
	logic [15:0] sample_count_q;

	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_inc_q <= '0;
			amplitude_q <= '0;
			sample_count_q <= 16'd1;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				ssg_pkg::REG_PHASE_INC: phase_inc_q <= pwdata;
				ssg_pkg::REG_AMPLITUDE: amplitude_q <= pwdata[15:0];
				ssg_pkg::REG_SAMPLE_COUNT: sample_count_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			ssg_pkg::REG_PHASE_INC: prdata = phase_inc_q;
			ssg_pkg::REG_AMPLITUDE: prdata = {16'd0, amplitude_q};
			ssg_pkg::REG_SAMPLE_COUNT: prdata = {16'd0, sample_count_q};
			default: prdata = '0;
		endcase
	end

	// quarter-wave rom, built at elaboration
	ssg_pkg::mag_t rom [TAB_SIZE];
	for (genvar k = 0; k < TAB_SIZE; k++) begin : g_rom
		// q30 horner series, divisors 2n*(2n+1) from n = 8 down to 1
		localparam ssg_pkg::wide_t X =
			(ssg_pkg::wide_t'(k) * ssg_pkg::HALF_PI_Q30) / ssg_pkg::wide_t'(QUARTER_TABLE_DEPTH);
		localparam ssg_pkg::wide_t X2 = (X * X) >> 30;
		localparam ssg_pkg::wide_t T8 =
			ssg_pkg::Q30_ONE - ((X2 * ssg_pkg::Q30_ONE) >> 30) / 64'd272;
		localparam ssg_pkg::wide_t T7 = ssg_pkg::Q30_ONE - ((X2 * T8) >> 30) / 64'd210;
		localparam ssg_pkg::wide_t T6 = ssg_pkg::Q30_ONE - ((X2 * T7) >> 30) / 64'd156;
		localparam ssg_pkg::wide_t T5 = ssg_pkg::Q30_ONE - ((X2 * T6) >> 30) / 64'd110;
		localparam ssg_pkg::wide_t T4 = ssg_pkg::Q30_ONE - ((X2 * T5) >> 30) / 64'd72;
		localparam ssg_pkg::wide_t T3 = ssg_pkg::Q30_ONE - ((X2 * T4) >> 30) / 64'd42;
		localparam ssg_pkg::wide_t T2 = ssg_pkg::Q30_ONE - ((X2 * T3) >> 30) / 64'd20;
		localparam ssg_pkg::wide_t T1 = ssg_pkg::Q30_ONE - ((X2 * T2) >> 30) / 64'd6;
		localparam ssg_pkg::wide_t S = (X * T1) >> 30;
		localparam ssg_pkg::wide_t R =
			(S * ssg_pkg::wide_t'(ssg_pkg::PEAK) + (ssg_pkg::wide_t'(1) << 29)) >> 30;
		assign rom[k] = ssg_pkg::mag_t'(R);
	end

	// pipe control
	logic v_s1, v_s2, out_valid_q;
	logic adv, accept;
	assign adv = !(out_valid_q && out_stall);
	assign in_stall = !adv;
	assign accept = in_valid && adv;

	// phase accumulator and run position
	logic [PHASE_BITS-1:0] phase_q, phase_cur;
	logic [15:0] idx_q, idx_cur, count_c;
	logic [1:0] quad_c;
	logic [ADDR_BITS-1:0] tab_idx_c, addr_c;
	logic peak_c, last_c;

	assign phase_cur = restart ? '0 : phase_q;
	assign idx_cur = restart ? '0 : idx_q;
	assign quad_c = phase_cur[PHASE_BITS-1 -: 2];
	assign tab_idx_c = phase_cur[PHASE_BITS-3 -: ADDR_BITS];
	// odd quadrants run the table backwards
	assign addr_c = quad_c[0] ? (ADDR_BITS'(0) - tab_idx_c) : tab_idx_c;
	assign peak_c = quad_c[0] && (tab_idx_c == '0);
	assign count_c = (sample_count_q == 16'd0) ? 16'd1 : sample_count_q;
	assign last_c = ({1'b0, idx_cur} + 17'd1) >= {1'b0, count_c};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			idx_q <= '0;
		end else if (accept) begin
			if (last_c) begin
				phase_q <= '0;
				idx_q <= '0;
			end else begin
				phase_q <= phase_cur + PHASE_BITS'(phase_inc_q);
				idx_q <= idx_cur + 16'd1;
			end
		end
	end

	// amplitude magnitude, -32768 clamps to the peak
	logic [15:0] amp_abs_c;
	ssg_pkg::mag_t amp_mag_c;
	assign amp_abs_c = amplitude_q[15] ? (16'd0 - amplitude_q) : amplitude_q;
	assign amp_mag_c = amp_abs_c[15] ? ssg_pkg::mag_t'(ssg_pkg::PEAK) : amp_abs_c[14:0];

	// stage 1: rom read
	ssg_pkg::mag_t rom_s1, amp_s1;
	logic peak_s1, neg_s1, last_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			rom_s1 <= rom[addr_c];
			amp_s1 <= amp_mag_c;
			peak_s1 <= peak_c;
			neg_s1 <= amplitude_q[15] ^ quad_c[1];
			last_s1 <= last_c;
		end
	end

	// stage 2: multiply
	ssg_pkg::mag_t tab_c;
	logic [29:0] prod_s2;
	logic neg_s2, last_s2;
	assign tab_c = peak_s1 ? ssg_pkg::mag_t'(ssg_pkg::PEAK) : rom_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= 30'(amp_s1) * 30'(tab_c);
			neg_s2 <= neg_s1;
			last_s2 <= last_s1;
		end
	end

	// stage 3: divide by 32767, estimate never overshoots and is short by at most one
	logic [30:0] est_sum_c;
	logic [15:0] q0_c, q_c;
	logic [30:0] qm_c, rem_c;
	logic [15:0] sample_q;
	logic last_q;

	assign est_sum_c = {1'b0, prod_s2} + 31'(prod_s2 >> 15);
	assign q0_c = est_sum_c[30:15];
	assign qm_c = {q0_c[15:0], 15'd0} - 31'(q0_c);
	assign rem_c = {1'b0, prod_s2} - qm_c;
	assign q_c = (rem_c >= 31'(ssg_pkg::PEAK)) ? (q0_c + 16'd1) : q0_c;

	always_ff @(posedge clk) begin
		if (adv) begin
			sample_q <= neg_s2 ? (16'd0 - q_c) : q_c;
			last_q <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			out_valid_q <= v_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign sample = sample_q;
	assign last = last_q;

	a_run_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_c |=> phase_q == '0 && idx_q == '0)
		else $error("run did not restart at phase zero after its last sample");

	a_div_correct: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> rem_c < 31'(2 * ssg_pkg::PEAK))
		else $error("divide estimate off by more than one");

	a_sample_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sample != 16'h8000)
		else $error("sample outside the symmetric range");

endmodule

FILE: test/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_CYCLES = 6;

	typedef struct packed {
		logic [15:0] value;
		logic        last;
	} sine_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        restart = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] sample;
	logic        last;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	sine_sample_generator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.restart  (restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample   (sample),
		.last     (last),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// oscillator copy used for prediction
	logic [15:0]        sine_quarter [256];
	logic [31:0]        nco_inc = '0;
	logic signed [15:0] nco_amp = '0;
	logic [15:0]        nco_count = 16'd1;
	logic [31:0]        nco_phase = '0;
	logic [15:0]        nco_index = '0;

	sine_beat_t  pending_samples [$];
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	function automatic logic [15:0] quarter_entry(int k);
		longint unsigned k64;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		longint unsigned d;
		k64 = longint'(k);
		x = (k64 * 64'd1686629713) / 64'd256;
		x2 = (x * x) >> 30;
		t = 64'd1 << 30;
		for (int n = 8; n >= 1; n--) begin
			d = longint'(2 * n * (2 * n + 1));
			t = (64'd1 << 30) - ((x2 * t) >> 30) / d;
		end
		s = (x * t) >> 30;
		return 16'((s * 64'd32767 + (64'd1 << 29)) >> 30);
	endfunction

	function automatic void next_sine_sample(logic rs);
		logic [1:0]  quad;
		logic [7:0]  slot;
		int          tab_mag;
		int          amp;
		int          amp_mag;
		int          prod;
		bit          neg;
		int          count;
		sine_beat_t  beat;
		if (rs) begin
			nco_phase = '0;
			nco_index = '0;
		end
		quad = nco_phase[31:30];
		slot = nco_phase[29:22];
		if (quad[0])
			tab_mag = (slot == 0) ? 32767 : int'(sine_quarter[256 - int'(slot)]);
		else
			tab_mag = int'(sine_quarter[slot]);
		amp = nco_amp;
		neg = amp < 0;
		amp_mag = neg ? -amp : amp;
		if (amp_mag > 32767)
			amp_mag = 32767;
		if (quad[1])
			neg = !neg;
		prod = (amp_mag * tab_mag) / 32767;
		if (neg)
			prod = -prod;
		count = (nco_count == 0) ? 1 : int'(nco_count);
		beat.value = prod[15:0];
		beat.last = (int'(nco_index) + 1 >= count);
		if (beat.last) begin
			nco_phase = '0;
			nco_index = '0;
		end else begin
			nco_phase = nco_phase + nco_inc;
			nco_index = nco_index + 16'd1;
		end
		pending_samples = {pending_samples, beat};
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// results are checked before this edge's input beat is predicted
	always @(posedge clk) begin
		sine_beat_t want;
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_samples.size() == 0) begin
				report_mismatch($sformatf("sample %0d with nothing expected", $signed(sample)));
			end else begin
				want = pending_samples.pop_front();
				if (sample !== want.value)
					report_mismatch($sformatf("sample %0d, expected %0d",
						$signed(sample), $signed(want.value)));
				if (last !== want.last)
					report_mismatch($sformatf("last %b, expected %b", last, want.last));
			end
		end
		if (arst_n && in_valid && !in_stall)
			next_sine_sample(restart);
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	initial begin
		wait (cycles >= CYCLE_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	task automatic send_sample(input logic rs);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		restart <= rs;
		do @(posedge clk); while (in_stall);
	endtask

	// the first edge lets the last accepted beat reach the expected queue
	task automatic wait_drained();
		do @(posedge clk); while (pending_samples.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			ssg_pkg::REG_PHASE_INC:    nco_inc = val;
			ssg_pkg::REG_AMPLITUDE:    nco_amp = val[15:0];
			ssg_pkg::REG_SAMPLE_COUNT: nco_count = val[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_oscillator(input logic [31:0] inc, input logic [15:0] amp,
			input logic [15:0] cnt);
		write_reg(ssg_pkg::REG_PHASE_INC, inc);
		write_reg(ssg_pkg::REG_AMPLITUDE, {16'd0, amp});
		write_reg(ssg_pkg::REG_SAMPLE_COUNT, {16'd0, cnt});
	endtask

	task automatic finish_burst();
		in_valid <= 1'b0;
		wait_drained();
	endtask

	// registers at reset: zero amplitude, one-sample runs
	task automatic test_reset_defaults();
		send_sample(1'b0);
		send_sample(1'b1);
		finish_burst();
	endtask

	// quarter-turn steps land exactly on every quadrant boundary
	task automatic test_quadrant_edges();
		set_oscillator(32'h4000_0000, 16'h7FFF, 16'd8);
		send_sample(1'b1);
		repeat (4) send_sample(1'b0);
		finish_burst();
	endtask

	// most negative amplitude clamps to -32767; -32767, zero and one are tried as well
	task automatic test_amplitude_extremes();
		logic [15:0] amps [4];
		amps = '{16'h8000, 16'h8001, 16'h0000, 16'h0001};
		set_oscillator(32'h2AAA_AAAB, 16'h7FFF, 16'd65535);
		foreach (amps[k]) begin
			write_reg(ssg_pkg::REG_AMPLITUDE, {16'd0, amps[k]});
			send_sample(k == 0);
			finish_burst();
		end
	endtask

	// a zero count behaves as one: every beat is last
	task automatic test_zero_count();
		set_oscillator(32'h1111_1111, 16'h4000, 16'd0);
		repeat (3) send_sample(1'b0);
		finish_burst();
	endtask

	// lowering the count past the running index ends the run on the next beat
	task automatic test_lowered_count();
		set_oscillator(32'h0765_4321, 16'hC000, 16'd20);
		send_sample(1'b1);
		repeat (3) send_sample(1'b0);
		finish_burst();
		write_reg(ssg_pkg::REG_SAMPLE_COUNT, 32'd3);
		repeat (2) send_sample(1'b0);
		finish_burst();
	endtask

	task automatic test_full_increment();
		set_oscillator(32'hFFFF_FFFF, 16'h7FFF, 16'd65535);
		send_sample(1'b1);
		repeat (2) send_sample(1'b0);
		finish_burst();
	endtask

	task automatic load_random_setting();
		logic [31:0] inc;
		logic [15:0] amp;
		logic [15:0] cnt;
		case ($urandom_range(3))
			0: inc = $urandom;
			1: inc = $urandom_range(1 << 24);
			2: inc = {2'($urandom_range(3)), 30'd0};
			default: inc = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
		endcase
		case ($urandom_range(7))
			0: amp = 16'h8000;
			1: amp = $urandom_range(1) ? 16'h7FFF : 16'h8001;
			default: amp = 16'($urandom);
		endcase
		case ($urandom_range(9))
			0: cnt = 16'd0;
			1: cnt = 16'hFFFF;
			2: cnt = 16'($urandom);
			default: cnt = 16'($urandom_range(40, 1));
		endcase
		set_oscillator(inc, amp, cnt);
	endtask

	// bursts of random restarts; some bursts keep the setting and only pause
	task automatic test_random_runs(input int beats, input int unsigned s_idle,
			input int unsigned r_stall);
		int sent;
		int burst;
		send_idle_pct = s_idle;
		recv_stall_pct = r_stall;
		sent = 0;
		while (sent < beats) begin
			if ($urandom_range(3) != 0)
				load_random_setting();
			burst = $urandom_range(80, 10);
			repeat (burst) send_sample($urandom_range(19) == 0);
			sent += burst;
			finish_burst();
		end
	endtask

	initial begin
		for (int k = 0; k < 256; k++)
			sine_quarter[k] = quarter_entry(k);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 20;
		recv_stall_pct = 51;
		test_reset_defaults();
		test_quadrant_edges();
		test_amplitude_extremes();
		test_zero_count();
		test_lowered_count();
		test_full_increment();
		test_random_runs(400, 20, 51);
		test_random_runs(400, 51, 20);
		test_random_runs(400, 0, 0);
		wait_drained();
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: sine_sample_generator.f
hw/rtl/ssg_pkg.sv
hw/rtl/sine_sample_generator.sv
test/testbench.sv
